// File: design/indexed_color_raster_op_pixel_assert.svh
// Assertion macros for the indexed colour raster-op block
`ifndef INDEXED_COLOR_RASTER_OP_PIXEL_ASSERT_SVH
`define INDEXED_COLOR_RASTER_OP_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define ICR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ICR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/icrop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrop_pkg
// Types and constants shared by the indexed colour raster-op block.
// ----------------------------------------------------------------------------
package icrop_pkg;
    localparam int COLOR_W = 24;
    localparam int SEG_W   = 9;

    typedef enum logic [1:0] {
        OP_PIXEL    = 2'd0,
        OP_LOAD_DST = 2'd1,
        OP_LOAD_SRC = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_ROP    = 3'd0,
        CFG_PLANES = 3'd1,
        CFG_SOLID  = 3'd2,
        CFG_SMODE  = 3'd3,
        CFG_FLAGS  = 3'd4,
        CFG_DSEG   = 3'd5,
        CFG_SSEG   = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        SRC_SOLID = 2'd0,
        SRC_BIT   = 2'd1,
        SRC_BYTE  = 2'd2,
        SRC_WORD  = 2'd3
    } src_mode_t;

    localparam logic [3:0] ROP_DST = 4'd10;

    // State of one colour search in flight
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               found;
        logic [SEG_W-1:0]   hit;
        logic               hit0;
        logic               hit255;
    } search_t;

    // Apply one of the sixteen boolean operations
    function automatic logic [31:0] rop_apply(input logic [3:0] op, input logic [31:0] s,
                                              input logic [31:0] d);
        logic [31:0] r;
        begin
            case (op)
                4'd0:    r = 32'd0;
                4'd1:    r = ~(s | d);
                4'd2:    r = ~s & d;
                4'd3:    r = ~s;
                4'd4:    r = s & ~d;
                4'd5:    r = ~d;
                4'd6:    r = s ^ d;
                4'd7:    r = ~(s & d);
                4'd8:    r = s & d;
                4'd9:    r = ~(s ^ d);
                4'd10:   r = d;
                4'd11:   r = ~s | d;
                4'd12:   r = s;
                4'd13:   r = s | ~d;
                4'd14:   r = s | d;
                default: r = 32'h00FF_FFFF;
            endcase
            return r;
        end
    endfunction
endpackage

// File: design/icrop_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrop_match
// Palette held in registers with a parallel colour search. Stage one compares
// the colour with every entry; stage two picks the first hit in the segment.
// ----------------------------------------------------------------------------
module icrop_match
    import icrop_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [7:0]         load_index,
    input  logic [COLOR_W-1:0] load_color,
    input  logic               advance,
    input  logic [COLOR_W-1:0] color,
    input  logic [SEG_W-1:0]   seg_start,
    input  logic [SEG_W-1:0]   seg_end,
    input  logic [9:0]         read_index,
    output search_t            result,
    output logic [COLOR_W-1:0] read_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam logic [10:0] ENT_LIMIT = 11'(ENTRIES);

    logic [COLOR_W-1:0] pal_reg [ENTRIES];
    logic [ENTRIES-1:0] eq_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [SEG_W-1:0]   start_reg, end_reg;
    logic [ENTRIES-1:0] hits;
    logic [IW-1:0]      wr_index;
    logic [10:0]        far_first;
    logic               zero_far;
    search_t            result_next;

    assign wr_index = IW'(load_index);

    // Write a palette entry
    always_ff @(posedge clk)
    begin
        if (load && ({3'b000, load_index} < ENT_LIMIT))
            pal_reg[wr_index] <= load_color;
    end

    // Compare every entry
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < ENTRIES; k++)
                eq_reg[k] <= (pal_reg[k] == color);
            color_reg <= color;
            start_reg <= seg_start;
            end_reg   <= seg_end;
        end
    end

    // Pick the lowest hit inside the segment; indices beyond the table read
    // as zero, so a black colour hits the first of them inside the segment
    always_comb
    begin
        for (int k = 0; k < ENTRIES; k++)
            hits[k] = eq_reg[k] && (10'(k) >= {1'b0, start_reg})
                      && (10'(k) < {1'b0, end_reg});
        far_first = ({2'b00, start_reg} >= ENT_LIMIT) ? {2'b00, start_reg} : ENT_LIMIT;
        zero_far  = (color_reg == '0) && (far_first < {2'b00, end_reg});
        result_next.color  = color_reg;
        result_next.found  = (|hits) || zero_far;
        result_next.hit    = far_first[SEG_W-1:0];
        for (int k = ENTRIES - 1; k >= 0; k--)
            if (hits[k])
                result_next.hit = SEG_W'(k);
        result_next.hit0   = eq_reg[0];
        result_next.hit255 = (ENTRIES > 255) ? eq_reg[(ENTRIES > 255) ? 255 : 0]
                                             : (color_reg == '0);
    end

    // Hold the search result for the last stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result <= '0;
        else if (advance)
            result <= result_next;
    end

    // Map through the palette; beyond the table reads zero
    always_comb
    begin
        if ({1'b0, read_index} < ENT_LIMIT)
            read_data = pal_reg[read_index[IW-1:0]];
        else
            read_data = '0;
    end
endmodule

// File: design/indexed_color_raster_op_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_color_raster_op_pixel
// Per-pixel raster operation on indexed colour kept in a true-colour buffer.
//
//   channel   | handshake       | payload
//   in        | in_valid/stall  | opcode dst_pixel src_pixel entry_index ...
//   out       | out_valid/stall | new_pixel
//   cfg       | cfg_we          | cfg_index cfg_data
//
// Four stages: register, palette compare, hit select, rop/merge/palette map.
// One word per cycle when out is not stalled and no destination palette load is held.
// A destination palette load right behind a pixel is held off so that the pixel
// maps through the old entry.
// A stall freezes every stage together. Reset clears valid bits and sets the config
// registers to their defaults; palettes are undefined until loaded.
// ----------------------------------------------------------------------------
`include "indexed_color_raster_op_pixel_assert.svh"
module indexed_color_raster_op_pixel
    import icrop_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] dst_pixel,
    input  logic [31:0] src_pixel,
    input  logic [7:0]  entry_index,
    input  logic [23:0] entry_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] new_pixel,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    logic [3:0]  rop_reg;
    logic [23:0] planes_reg, solid_reg;
    logic [1:0]  smode_reg;
    logic [2:0]  flags_reg;
    logic [17:0] dseg_reg, sseg_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rop_reg    <= 4'd12;
            planes_reg <= 24'hFFFFFF;
            solid_reg  <= '0;
            smode_reg  <= '0;
            flags_reg  <= '0;
            dseg_reg   <= 18'd65536;
            sseg_reg   <= 18'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROP:    rop_reg    <= cfg_data[3:0];
                CFG_PLANES: planes_reg <= cfg_data;
                CFG_SOLID:  solid_reg  <= cfg_data;
                CFG_SMODE:  smode_reg  <= cfg_data[1:0];
                CFG_FLAGS:  flags_reg  <= cfg_data[2:0];
                CFG_DSEG:   dseg_reg   <= cfg_data[17:0];
                CFG_SSEG:   sseg_reg   <= cfg_data[17:0];
                default:    ;
            endcase
        end
    end

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]  op1_reg;
    logic [31:0] d1_reg, s1_reg, d2_reg, s2_reg, d3_reg, s3_reg;
    logic [7:0]  ei1_reg;
    logic [23:0] ec1_reg;
    logic [31:0] res_reg;
    logic        ld_dst, ld_src, is_pix;
    logic        ld_hold;

    assign advance   = !(v4_reg && out_stall);
    assign ld_hold   = v1_reg && is_pix && (opcode == OP_LOAD_DST);
    assign in_stall  = !advance || ld_hold;
    assign out_valid = v4_reg;
    assign new_pixel = res_reg;
    assign is_pix    = (op1_reg == OP_PIXEL) && (rop_reg != ROP_DST);
    assign ld_dst    = advance && v1_reg && (op1_reg == OP_LOAD_DST);
    assign ld_src    = advance && v1_reg && (op1_reg == OP_LOAD_SRC);

    // Advance valid bits; loads, and pixels while the rop keeps the destination, drop out after stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid && !ld_hold;
            v2_reg <= v1_reg && is_pix;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= opcode;
            d1_reg  <= dst_pixel;
            s1_reg  <= src_pixel;
            ei1_reg <= entry_index;
            ec1_reg <= entry_color;
            d2_reg  <= d1_reg;
            s2_reg  <= s1_reg;
            d3_reg  <= d2_reg;
            s3_reg  <= s2_reg;
        end
    end

    search_t     dres, sres;
    logic [23:0] drd, srd_unused;
    logic [9:0]  map_index;

    icrop_match #(.ENTRIES(PALETTE_ENTRIES)) u_dmatch (
        .clk(clk), .rst_n(rst_n), .load(ld_dst), .load_index(ei1_reg),
        .load_color(ec1_reg), .advance(advance), .color(d1_reg[23:0]),
        .seg_start(dseg_reg[8:0]), .seg_end(dseg_reg[17:9]),
        .read_index(map_index), .result(dres), .read_data(drd));

    icrop_match #(.ENTRIES(PALETTE_ENTRIES)) u_smatch (
        .clk(clk), .rst_n(rst_n), .load(ld_src), .load_index(ei1_reg),
        .load_color(ec1_reg), .advance(advance), .color(s1_reg[23:0]),
        .seg_start(sseg_reg[8:0]), .seg_end(sseg_reg[17:9]),
        .read_index(10'd0), .result(sres), .read_data(srd_unused));

    function automatic logic [31:0] fallback(input search_t r, input logic full,
                                             input logic [8:0] st, input logic [8:0] en);
        logic [31:0] x;
        begin
            x = r.found ? {23'd0, r.hit} : {8'd0, r.color};
            if (full || (!r.found && st <= en))
            begin
                if (r.hit0)
                    x = 32'd0;
                else if (r.hit255 || !r.found || ({15'd0, r.hit} == r.color))
                    x = 32'd255;
            end
            return x;
        end
    endfunction

    logic        full, dix, six;
    logic [31:0] old, s, d, planes, merged;

    // Convert, form the source, apply the rop and merge
    always_comb
    begin
        dix    = flags_reg[0];
        six    = flags_reg[1];
        full   = (dix || six) && (planes_reg >= 24'd256);
        planes = full ? 32'd255 : {8'd0, planes_reg};
        old    = dix ? fallback(dres, full, dseg_reg[8:0], dseg_reg[17:9]) : d3_reg;
        case (smode_reg)
            SRC_SOLID: s = {8'd0, solid_reg};
            SRC_BIT:   s = {32{s3_reg[0] ^ flags_reg[2]}};
            SRC_BYTE:  s = {24'd0, s3_reg[7:0]};
            default:   s = six ? fallback(sres, full, sseg_reg[8:0], sseg_reg[17:9]) : s3_reg;
        endcase
        d         = rop_apply(rop_reg, s, old);
        merged    = (~planes & old) | (planes & d);
        map_index = (merged[31:10] != '0) ? 10'h3FF : merged[9:0];
    end

    // Map an indexed result through the palette, else pass the merged value
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= dix ? {8'd0, drd} : merged;
    end

    `ICR_ASSERT_IMP(a_stall_when_held, clk, rst_n, out_valid && out_stall, in_stall)
    `ICR_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid)
    `ICR_ASSERT_NEXT(a_flow, clk, rst_n, v3_reg && !in_stall, out_valid)
endmodule
